// ===== rtl/epdf_pkg.sv =====
// ----------------------------------------------------------------------------
// Echo pulse distance filter package
// Shared widths, register indexes, reset values and the distance scaling
// constant.
// ----------------------------------------------------------------------------
package epdf_pkg;

   localparam int CountBits = 16;
   localparam int DistBits  = 14;
   localparam int FiltBits  = 16;
   localparam int TolBits   = 8;
   localparam int CsrBits   = 16;
   localparam int CsrIdxBits = 2;

   // Register indexes on the configuration port.
   localparam logic [CsrIdxBits-1:0] CsrMinDistance = 2'd0;
   localparam logic [CsrIdxBits-1:0] CsrMaxDistance = 2'd1;
   localparam logic [CsrIdxBits-1:0] CsrTolerance   = 2'd2;

   localparam logic [FiltBits-1:0] MinDistanceReset = 16'd0;
   localparam logic [FiltBits-1:0] MaxDistanceReset = 16'd100;
   localparam logic [TolBits-1:0]  ToleranceReset   = 8'd4;

   // floor(w*17/100) is computed as (w * 17 * ceil(2^32/100)) >> 32. The
   // rounding error of the reciprocal stays below one unit for any width
   // below 2^30, so the quotient is exact for every 16-bit width.
   localparam int RecipShift = 32;
   localparam int MulConstBits = 30;
   localparam logic [MulConstBits-1:0] DistMulConst = 30'd730144441;
   localparam int ProdBits = CountBits + MulConstBits;

endpackage

// ===== rtl/echo_pulse_distance_filter.sv =====
// ----------------------------------------------------------------------------
// Echo pulse distance filter
// Converts pairs of echo edge captures into a distance and filters it by
// range and by largest change.
// ----------------------------------------------------------------------------
// Each req transfer carries one timer capture; captures alternate between a
// rising edge (stored as the pulse start) and a falling edge (ends the pulse
// and produces a distance). Every capture produces exactly one rsp transfer.
// The block is a two-stage pipeline: an input register, then logic
// (wrap-aware subtract, one constant multiply, range and tolerance compares)
// into the result register. It takes one capture per clock while the output
// is not stalled. The user must write configuration through the csr port
// only while idle; the block itself does not enforce this.
module echo_pulse_distance_filter
   import epdf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [CountBits-1:0]  req_capture_value,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_expect_falling,
   output logic                  rsp_measure_done,
   output logic [DistBits-1:0]   rsp_raw_distance,
   output logic [FiltBits-1:0]   rsp_filtered_out,
   output logic                  rsp_accepted,
   input  logic                  csr_write_en,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [CsrBits-1:0]    csr_wdata
);

   // Configuration registers
   logic [FiltBits-1:0]  min_dist_ff;
   logic [FiltBits-1:0]  max_dist_ff;
   logic [TolBits-1:0]   tol_ff;

   // Input stage
   logic                 in_valid_ff;
   logic [CountBits-1:0] in_cap_ff;

   // Block state
   logic                 waiting_falling_ff, waiting_falling_in;
   logic [CountBits-1:0] start_count_ff, start_count_in;
   logic [DistBits-1:0]  last_raw_ff, last_raw_in;
   logic [FiltBits-1:0]  filtered_ff, filtered_in;
   logic                 have_first_ff, have_first_in;

   // Result stage
   logic                 out_valid_ff;
   logic                 out_done_ff, out_done_in;
   logic                 out_acc_ff, out_acc_in;

   logic                 advance;
   logic [CountBits-1:0] width;
   logic [ProdBits-1:0]  product;
   logic [DistBits-1:0]  dist_calc;
   logic signed [17:0]   delta;
   logic signed [17:0]   tol_s;
   logic                 in_range;
   logic                 in_tol;

   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_dist_ff <= MinDistanceReset;
         max_dist_ff <= MaxDistanceReset;
         tol_ff      <= ToleranceReset;
      end else if (csr_write_en) begin
         case (csr_index)
            CsrMinDistance: min_dist_ff <= csr_wdata;
            CsrMaxDistance: max_dist_ff <= csr_wdata;
            CsrTolerance:   tol_ff      <= csr_wdata[TolBits-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_cap_ff <= req_capture_value;
      end
   end

   // When the end count does not exceed the start, the wrap rule adds the
   // distance to the counter top, which in 16 bits is end - start - 1.
   assign width     = in_cap_ff - start_count_ff
                      - CountBits'(in_cap_ff <= start_count_ff);
   assign product   = ProdBits'(width) * ProdBits'(DistMulConst);
   assign dist_calc = product[RecipShift +: DistBits];

   assign in_range = ({2'b00, dist_calc} >= min_dist_ff) &&
                     ({2'b00, dist_calc} <= max_dist_ff);
   assign delta    = $signed({4'b0000, dist_calc}) - $signed({2'b00, filtered_ff});
   assign tol_s    = $signed({10'd0, tol_ff});
   assign in_tol   = (delta >= -tol_s) && (delta <= tol_s);

   always_comb begin
      waiting_falling_in = waiting_falling_ff;
      start_count_in     = start_count_ff;
      last_raw_in        = last_raw_ff;
      filtered_in        = filtered_ff;
      have_first_in      = have_first_ff;
      out_done_in        = 1'b0;
      out_acc_in         = 1'b0;
      if (!waiting_falling_ff) begin
         start_count_in     = in_cap_ff;
         waiting_falling_in = 1'b1;
      end else begin
         last_raw_in        = dist_calc;
         out_done_in        = 1'b1;
         waiting_falling_in = 1'b0;
         if (!have_first_ff || (in_range && in_tol)) begin
            filtered_in   = {2'b00, dist_calc};
            have_first_in = 1'b1;
            out_acc_in    = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         waiting_falling_ff <= 1'b0;
         start_count_ff     <= '0;
         last_raw_ff        <= '0;
         filtered_ff        <= '0;
         have_first_ff      <= 1'b0;
         out_valid_ff       <= 1'b0;
      end else begin
         if (advance) begin
            waiting_falling_ff <= waiting_falling_in;
            start_count_ff     <= start_count_in;
            last_raw_ff        <= last_raw_in;
            filtered_ff        <= filtered_in;
            have_first_ff      <= have_first_in;
            out_valid_ff       <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_done_ff <= out_done_in;
         out_acc_ff  <= out_acc_in;
      end
   end

   // The state registers double as the result payload for the fields that
   // show state after the update.
   assign rsp_valid          = out_valid_ff;
   assign rsp_expect_falling = waiting_falling_ff;
   assign rsp_measure_done   = out_done_ff;
   assign rsp_raw_distance   = last_raw_ff;
   assign rsp_filtered_out   = filtered_ff;
   assign rsp_accepted       = out_acc_ff;

   a_acc_needs_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_measure_done)
      else $error("accepted result without a completed measurement");

   a_done_polarity: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_measure_done != rsp_expect_falling))
      else $error("edge polarity does not match measurement status");

   a_first_sticks: assert property (@(posedge clock) disable iff (reset)
      have_first_ff |=> have_first_ff)
      else $error("first-value flag cleared outside reset");

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_ready |=> $stable(filtered_ff) && $stable(last_raw_ff))
      else $error("state changed while result stalled");

endmodule

// ===== dv/echo_pulse_distance_filter_tb.sv =====
// ----------------------------------------------------------------------------
// Echo pulse distance filter testbench
// Streams echo edge captures into the block with random gaps and output
// stalls. A behavioral copy of the edge pairing, distance conversion and
// range/tolerance filter predicts every result, and each result is checked
// field by field. The run goes through several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module echo_pulse_distance_filter_tb;
   import epdf_pkg::*;

   localparam int CycleLimit = 1000000;
   localparam int MaxPrinted = 50;
   // Index 3 has no register behind it; writes to it must be ignored.
   localparam logic [CsrIdxBits-1:0] CsrUnused = 2'd3;

   typedef struct packed {
      logic                expect_falling;
      logic                measure_done;
      logic [DistBits-1:0] raw_distance;
      logic [FiltBits-1:0] filtered_out;
      logic                accepted;
   } echo_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic [CountBits-1:0]  req_capture_value = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic                  rsp_expect_falling;
   logic                  rsp_measure_done;
   logic [DistBits-1:0]   rsp_raw_distance;
   logic [FiltBits-1:0]   rsp_filtered_out;
   logic                  rsp_accepted;
   logic                  csr_write_en = 1'b0;
   logic [CsrIdxBits-1:0] csr_index = '0;
   logic [CsrBits-1:0]    csr_wdata = '0;

   echo_pulse_distance_filter dut (.*);

   // Predicted block state and register copies.
   logic                 edge_is_falling = 1'b0;
   logic [CountBits-1:0] pulse_start = '0;
   logic [DistBits-1:0]  held_raw = '0;
   logic [FiltBits-1:0]  filt_dist = '0;
   logic                 have_first_dist = 1'b0;
   logic [FiltBits-1:0]  cfg_min_dist = MinDistanceReset;
   logic [FiltBits-1:0]  cfg_max_dist = MaxDistanceReset;
   logic [TolBits-1:0]   cfg_tol = ToleranceReset;

   logic [CountBits-1:0] capture_q[$];
   echo_result_type      echo_results_q[$];
   int                   error_count = 0;
   int                   cycle_count = 0;
   logic                 quiet_stretch = 1'b0;
   logic                 gen_falling = 1'b0;
   int                   gen_pushed = 0;

   initial begin
      forever #2 clock = ~clock;
   end

   // Advances the predicted state by one capture and returns the result.
   function automatic echo_result_type measure_echo_edge(logic [CountBits-1:0] cap);
      echo_result_type res;
      logic [CountBits:0] width;
      int dist_val;
      int lo_edge;
      int hi_edge;
      res.measure_done = 1'b0;
      res.accepted = 1'b0;
      if (!edge_is_falling) begin
         pulse_start = cap;
         edge_is_falling = 1'b1;
      end else begin
         // Equal counts take the wrap branch and give the largest width.
         if (cap > pulse_start)
            width = cap - pulse_start;
         else
            width = ({1'b0, 16'hFFFF} - pulse_start) + cap;
         dist_val = (int'(width) * 17) / 100;
         if (dist_val > 16383)
            dist_val = 16383;
         held_raw = dist_val[DistBits-1:0];
         res.measure_done = 1'b1;
         if (!have_first_dist) begin
            filt_dist = dist_val[FiltBits-1:0];
            have_first_dist = 1'b1;
            res.accepted = 1'b1;
         end else if (dist_val >= int'(cfg_min_dist) && dist_val <= int'(cfg_max_dist)) begin
            lo_edge = int'(filt_dist) - int'(cfg_tol);
            hi_edge = int'(filt_dist) + int'(cfg_tol);
            if (dist_val >= lo_edge && dist_val <= hi_edge) begin
               filt_dist = dist_val[FiltBits-1:0];
               res.accepted = 1'b1;
            end
         end
         edge_is_falling = 1'b0;
      end
      res.expect_falling = edge_is_falling;
      res.raw_distance = held_raw;
      res.filtered_out = filt_dist;
      return res;
   endfunction

   function automatic int pick_gap();
      int r;
      if (quiet_stretch)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      error_count++;
      if (error_count <= MaxPrinted)
         $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
   endtask

   // Alternates stretches with idling and stretches without.
   always @(posedge clock) begin : stretch_ctl
      int stretch_left;
      if (stretch_left <= 0) begin
         stretch_left = $urandom_range(50, 400);
         quiet_stretch <= ($urandom_range(0, 3) == 0);
      end else begin
         stretch_left--;
      end
   end

   // Capture driver.
   always @(posedge clock) begin : capture_driver
      int gap_left;
      logic next_valid;
      logic [CountBits-1:0] next_cap;
      if (reset) begin
         req_valid <= 1'b0;
         gap_left = 0;
      end else begin
         next_valid = req_valid;
         next_cap = req_capture_value;
         if (req_valid && req_ready) begin
            echo_results_q.push_back(measure_echo_edge(req_capture_value));
            next_valid = 1'b0;
            gap_left = pick_gap();
         end
         if (!next_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (capture_q.size() > 0) begin
               next_valid = 1'b1;
               next_cap = capture_q.pop_front();
            end
         end
         req_valid <= next_valid;
         req_capture_value <= next_cap;
      end
   end

   // Result monitor and checker.
   always @(posedge clock) begin : result_monitor
      int stall_left;
      echo_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (echo_results_q.size() == 0) begin
               report_mismatch("unexpected transfer", 1, 0);
            end else begin
               want = echo_results_q.pop_front();
               if (rsp_expect_falling !== want.expect_falling)
                  report_mismatch("expect_falling", rsp_expect_falling, want.expect_falling);
               if (rsp_measure_done !== want.measure_done)
                  report_mismatch("measure_done", rsp_measure_done, want.measure_done);
               if (rsp_raw_distance !== want.raw_distance)
                  report_mismatch("raw_distance", rsp_raw_distance, want.raw_distance);
               if (rsp_filtered_out !== want.filtered_out)
                  report_mismatch("filtered_out", rsp_filtered_out, want.filtered_out);
               if (rsp_accepted !== want.accepted)
                  report_mismatch("accepted", rsp_accepted, want.accepted);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 3) == 0)
               stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CycleLimit) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic push_capture(logic [CountBits-1:0] cap);
      capture_q.push_back(cap);
      gen_falling = ~gen_falling;
      gen_pushed++;
   endtask

   // Pushes a rising/falling pair, closing any open pulse first.
   task automatic push_pair(logic [CountBits-1:0] start_cap, logic [CountBits-1:0] end_cap);
      if (gen_falling)
         push_capture(16'($urandom_range(0, 65535)));
      push_capture(start_cap);
      push_capture(end_cap);
   endtask

   function automatic int width_for(int dist_val);
      int w;
      w = (dist_val * 100 + 16) / 17;
      return (w > 65535) ? 65535 : w;
   endfunction

   // Waits until every capture has been taken and every result checked.
   task automatic wait_idle();
      do
         @(negedge clock);
      while (capture_q.size() != 0 || req_valid || echo_results_q.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [CsrIdxBits-1:0] idx, logic [CsrBits-1:0] data);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         CsrMinDistance: cfg_min_dist = data;
         CsrMaxDistance: cfg_max_dist = data;
         CsrTolerance:   cfg_tol = data[TolBits-1:0];
         default: ;
      endcase
   endtask

   // One register setting followed by random captures. Most of them form
   // pulses whose distance walks from the current filtered value, so that
   // the tolerance window is hit often.
   task automatic run_phase(int min_d, int max_d, int tol, int count, int lo, int hi, int step);
      int target;
      int r;
      int w;
      logic [CountBits-1:0] s;
      wait_idle();
      write_csr(CsrMinDistance, CsrBits'(min_d));
      write_csr(CsrMaxDistance, CsrBits'(max_d));
      write_csr(CsrTolerance, CsrBits'(tol));
      target = int'(filt_dist);
      gen_pushed = 0;
      while (gen_pushed < count) begin
         r = $urandom_range(0, 99);
         if (r < 70) begin
            target = target + $urandom_range(0, 2 * step) - step;
            if (target < lo)
               target = lo;
            if (target > hi)
               target = hi;
            w = width_for(target);
            if ($urandom_range(0, 3) == 0)
               w = w + $urandom_range(0, 5);
            s = 16'($urandom_range(0, 65535));
            push_pair(s, s + 16'(w));
         end else if (r < 85) begin
            push_capture(16'($urandom_range(0, 65535)));
         end else begin
            s = 16'($urandom_range(0, 65535));
            case ($urandom_range(0, 3))
               0: push_pair(s, s);
               1: push_pair(s, s - 16'd1);
               2: push_pair(16'h0000, 16'hFFFF);
               default: push_pair(16'hFFFF, 16'($urandom_range(0, 100)));
            endcase
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed captures under the reset register values. The first pulse
      // is a wrap with zero width and must be accepted unconditionally.
      push_pair(16'hFFFF, 16'h0000);
      push_pair(16'd1000, 16'd1020);
      push_pair(16'h0000, 16'hFFFF);
      push_pair(16'h8000, 16'h8000);
      push_pair(16'd200, 16'd247);
      push_pair(16'd300, 16'd377);
      push_pair(16'd65000, 16'd500);
      push_pair(16'hAAAA, 16'h5555);
      push_pair(16'h5555, 16'hAAAA);
      push_capture(16'h1234);

      wait_idle();
      write_csr(CsrUnused, 16'hFFFF);
      run_phase(0, 65535, 255, 300, 20, 300, 80);
      run_phase(20, 300, 10, 400, 0, 320, 12);
      run_phase(200, 11140, 255, 250, 150, 11140, 300);
      run_phase(0, 11140, 0, 300, 0, 11140, 1);
      // Minimum above maximum: no pulse gets through.
      run_phase(300, 100, 50, 150, 0, 400, 40);
      run_phase(65535, 65535, 0, 100, 0, 11140, 2000);
      run_phase(0, 0, 0, 150, 0, 10, 3);
      run_phase(0, 100, 4, 150, 0, 120, 5);

      wait_idle();
      repeat (10) @(posedge clock);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
